@@ hw/rtl/dmx_widget_frame_receiver_macros.svh @@
// Assertion macros used by the frame receiver RTL.
`ifndef DMX_WIDGET_FRAME_RECEIVER_MACROS_SVH
`define DMX_WIDGET_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DMX_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dmx frame receiver check failed");

// Next-cycle implication, checked out of reset.
`define DMX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dmx frame receiver check failed");

`endif

@@ hw/rtl/dmx_wfr_pkg.sv @@
// Types and constants of the DMX widget frame receiver.
package dmx_wfr_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned StatusW  = 2;

  localparam logic [ByteW-1:0] StartMarkerReset  = 8'd126;
  localparam logic [ByteW-1:0] RecvLabelReset    = 8'd5;
  localparam logic [ByteW-1:0] StartCodeStd      = 8'h00;
  localparam logic [CountW-1:0] MinFrameLen      = 16'd2;

  localparam logic [CfgIdxW-1:0] CfgIdxStartMarker = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxRecvLabel   = 8'd1;

  localparam logic KindSlot   = 1'b0;
  localparam logic KindFinish = 1'b1;

  typedef enum logic [2:0] {
    PhHunt   = 3'd0,
    PhLabel  = 3'd1,
    PhLenLo  = 3'd2,
    PhLenHi  = 3'd3,
    PhStatus = 3'd4,
    PhSCode  = 3'd5,
    PhData   = 3'd6,
    PhEnd    = 3'd7
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] receive_label;
  } cfg_t;

  typedef struct packed {
    logic              result_kind;
    logic [ByteW-1:0]  slot_byte;
    logic [CountW-1:0] slot_index;
    logic              queue_overflow;
    logic              receive_overrun;
    logic              odd_start_code;
    logic              frame_last;
  } result_t;

endpackage

@@ hw/rtl/dmx_wfr_byte_if.sv @@
// Byte channel from the serial link.
interface dmx_wfr_byte_if;
  logic                           valid;
  logic                           ready;
  logic [dmx_wfr_pkg::ByteW-1:0]  rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/dmx_wfr_result_if.sv @@
// Result channel carrying slot words and frame-finished words.
interface dmx_wfr_result_if;
  logic                            valid;
  logic                            ready;
  logic                            result_kind;
  logic [dmx_wfr_pkg::ByteW-1:0]   slot_byte;
  logic [dmx_wfr_pkg::CountW-1:0]  slot_index;
  logic                            queue_overflow;
  logic                            receive_overrun;
  logic                            odd_start_code;
  logic                            frame_last;

  modport source (output valid, output result_kind, output slot_byte, output slot_index,
                  output queue_overflow, output receive_overrun, output odd_start_code,
                  output frame_last, input ready);
  modport sink   (input valid, input result_kind, input slot_byte, input slot_index,
                  input queue_overflow, input receive_overrun, input odd_start_code,
                  input frame_last, output ready);
endinterface

@@ hw/rtl/dmx_wfr_cfg_if.sv @@
// Configuration register write channel.
interface dmx_wfr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dmx_wfr_pkg::CfgIdxW-1:0] cfg_index;
  logic [dmx_wfr_pkg::ByteW-1:0]   cfg_data;

  modport source (output valid, output cfg_index, output cfg_data, input ready);
  modport sink   (input valid, input cfg_index, input cfg_data, output ready);
endinterface

@@ hw/rtl/dmx_wfr_parser.sv @@
// Frame parser state machine: one byte per accepted word, at most one result.
module dmx_wfr_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [dmx_wfr_pkg::ByteW-1:0]  byte_i,
  input  dmx_wfr_pkg::cfg_t              cfg_i,
  output logic                           res_valid_o,
  output dmx_wfr_pkg::result_t           res_o
);

  dmx_wfr_pkg::phase_e               phase_q, phase_d;
  logic [dmx_wfr_pkg::ByteW-1:0]     len_lo_q, len_lo_d;
  logic [dmx_wfr_pkg::CountW-1:0]    remain_q, remain_d;
  logic [dmx_wfr_pkg::CountW-1:0]    slot_cnt_q, slot_cnt_d;
  logic [dmx_wfr_pkg::StatusW-1:0]   status_q, status_d;
  logic                              scode_q, scode_d;
  logic [dmx_wfr_pkg::CountW-1:0]    frame_len;

  assign frame_len = {byte_i, len_lo_q};

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      unique case (phase_q)
        dmx_wfr_pkg::PhHunt: begin
          if (byte_i == cfg_i.start_marker) phase_d = dmx_wfr_pkg::PhLabel;
        end
        dmx_wfr_pkg::PhLabel: begin
          phase_d = (byte_i == cfg_i.receive_label) ? dmx_wfr_pkg::PhLenLo
                                                    : dmx_wfr_pkg::PhHunt;
        end
        dmx_wfr_pkg::PhLenLo:  phase_d = dmx_wfr_pkg::PhLenHi;
        dmx_wfr_pkg::PhLenHi: begin
          phase_d = (frame_len < dmx_wfr_pkg::MinFrameLen) ? dmx_wfr_pkg::PhHunt
                                                           : dmx_wfr_pkg::PhStatus;
        end
        dmx_wfr_pkg::PhStatus: phase_d = dmx_wfr_pkg::PhSCode;
        dmx_wfr_pkg::PhSCode: begin
          phase_d = (remain_q == '0) ? dmx_wfr_pkg::PhEnd : dmx_wfr_pkg::PhData;
        end
        dmx_wfr_pkg::PhData: begin
          if (remain_q == dmx_wfr_pkg::CountW'(1)) phase_d = dmx_wfr_pkg::PhEnd;
        end
        dmx_wfr_pkg::PhEnd:    phase_d = dmx_wfr_pkg::PhHunt;
        default:               phase_d = dmx_wfr_pkg::PhHunt;
      endcase
    end
  end

  // datapath registers and result word
  always_comb begin
    len_lo_d    = len_lo_q;
    remain_d    = remain_q;
    slot_cnt_d  = slot_cnt_q;
    status_d    = status_q;
    scode_d     = scode_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (accept_i) begin
      unique case (phase_q)
        dmx_wfr_pkg::PhLenLo: len_lo_d = byte_i;
        dmx_wfr_pkg::PhLenHi: begin
          if (frame_len >= dmx_wfr_pkg::MinFrameLen) begin
            remain_d = frame_len - dmx_wfr_pkg::MinFrameLen;
          end
        end
        dmx_wfr_pkg::PhStatus: status_d = byte_i[dmx_wfr_pkg::StatusW-1:0];
        dmx_wfr_pkg::PhSCode: begin
          scode_d    = (byte_i != dmx_wfr_pkg::StartCodeStd);
          slot_cnt_d = '0;
        end
        dmx_wfr_pkg::PhData: begin
          res_valid_o       = 1'b1;
          res_o.result_kind = dmx_wfr_pkg::KindSlot;
          res_o.slot_byte   = byte_i;
          res_o.slot_index  = slot_cnt_q;
          slot_cnt_d        = slot_cnt_q + dmx_wfr_pkg::CountW'(1);
          remain_d          = remain_q - dmx_wfr_pkg::CountW'(1);
        end
        dmx_wfr_pkg::PhEnd: begin
          // end byte value is ignored
          res_valid_o           = 1'b1;
          res_o.result_kind     = dmx_wfr_pkg::KindFinish;
          res_o.slot_index      = slot_cnt_q;
          res_o.queue_overflow  = status_q[0];
          res_o.receive_overrun = ~status_q[0] & status_q[1];
          res_o.odd_start_code  = scode_q;
          res_o.frame_last      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= dmx_wfr_pkg::PhHunt;
      len_lo_q   <= '0;
      remain_q   <= '0;
      slot_cnt_q <= '0;
      status_q   <= '0;
      scode_q    <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      len_lo_q   <= len_lo_d;
      remain_q   <= remain_d;
      slot_cnt_q <= slot_cnt_d;
      status_q   <= status_d;
      scode_q    <= scode_d;
    end
  end

endmodule

@@ hw/rtl/dmx_widget_frame_receiver.sv @@
// DMX widget receive-frame parser: byte in, slot and frame-finished words out.
//
// rx_i takes one link byte per word. Frames are start marker, receive label,
// 16-bit little-endian length, status, start code, length-2 slot bytes, end byte.
// res_o carries one word per slot byte (result_kind 0, with its slot index) and
// one frame-finished word per end byte (result_kind 1, status and start-code
// flags, slot count in slot_index). Header bytes give no word.
// cfg_i writes the start marker (index 0) and receive label (index 1); it is
// always ready, and other indexes are dropped. Write it only while idle.
// Each result word is registered, valid in the cycle after its byte is accepted;
// one byte is accepted per cycle unless res_o stalls. The result register is the
// only stage, so rx_i.ready is low only while a word is held and res_o.ready is
// low: a stalled receiver stalls the link side in the same cycle, no word lost.
// Reset (rst_ni low, async) returns the parser to hunting for a start marker,
// empties the result register and restores the register reset values.
`include "dmx_widget_frame_receiver_macros.svh"

module dmx_widget_frame_receiver (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  dmx_wfr_byte_if.sink              rx_i,
  dmx_wfr_cfg_if.sink               cfg_i,
  dmx_wfr_result_if.source          res_o
);

  dmx_wfr_pkg::cfg_t     cfg_q, cfg_d;
  dmx_wfr_pkg::result_t  par_res;
  dmx_wfr_pkg::result_t  res_q;
  logic                  par_valid;
  logic                  res_valid_q, res_valid_d;
  logic                  rx_acc;
  logic                  load;
  logic                  slot_flags;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      if (cfg_i.cfg_index == dmx_wfr_pkg::CfgIdxStartMarker) begin
        cfg_d.start_marker = cfg_i.cfg_data;
      end else if (cfg_i.cfg_index == dmx_wfr_pkg::CfgIdxRecvLabel) begin
        cfg_d.receive_label = cfg_i.cfg_data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker  <= dmx_wfr_pkg::StartMarkerReset;
      cfg_q.receive_label <= dmx_wfr_pkg::RecvLabelReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign rx_i.ready = ~res_valid_q | res_o.ready;
  assign rx_acc     = rx_i.valid & rx_i.ready;

  dmx_wfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (rx_acc),
    .byte_i      (rx_i.rx_byte),
    .cfg_i       (cfg_q),
    .res_valid_o (par_valid),
    .res_o       (par_res)
  );

  // result register
  assign load        = rx_acc & par_valid;
  assign res_valid_d = load | (res_valid_q & ~res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= par_res;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.result_kind     = res_q.result_kind;
  assign res_o.slot_byte       = res_q.slot_byte;
  assign res_o.slot_index      = res_q.slot_index;
  assign res_o.queue_overflow  = res_q.queue_overflow;
  assign res_o.receive_overrun = res_q.receive_overrun;
  assign res_o.odd_start_code  = res_q.odd_start_code;
  assign res_o.frame_last      = res_q.frame_last;

  // frame-finished flags, all clear on a slot word
  assign slot_flags = res_q.frame_last | res_q.queue_overflow | res_q.receive_overrun |
                      res_q.odd_start_code;

  `DMX_ASSERT_NOW(a_no_accept_when_full, clk_i, rst_ni, res_valid_q && !res_o.ready, !rx_i.ready)
  `DMX_ASSERT_NEXT(a_result_lands, clk_i, rst_ni, load, res_valid_q)
  `DMX_ASSERT_NOW(a_slot_flags_clear, clk_i, rst_ni, res_valid_q && !res_q.result_kind, !slot_flags)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the DMX widget receive-frame parser.
`timescale 1ns / 100ps

import dmx_wfr_pkg::*;

class frame_scoreboard;
  localparam int MaxReports = 20;

  logic [ByteW-1:0]   start_marker;
  logic [ByteW-1:0]   recv_label;
  phase_e             phase;
  logic [ByteW-1:0]   len_low;
  logic [CountW-1:0]  bytes_left;
  logic [CountW-1:0]  slot_no;
  logic [StatusW-1:0] status;
  logic               odd_code;
  result_t            expected_words[$];
  int                 errors;
  int                 reports;

  function new();
    start_marker = StartMarkerReset;
    recv_label   = RecvLabelReset;
    phase        = PhHunt;
    len_low      = '0;
    bytes_left   = '0;
    slot_no      = '0;
    status       = '0;
    odd_code     = 1'b0;
    errors       = 0;
    reports      = 0;
  endfunction

  function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] data);
    if (idx == CfgIdxStartMarker) start_marker = data;
    else if (idx == CfgIdxRecvLabel) recv_label = data;
  endfunction

  // Advance the frame parser by one link byte; queue the word it produces.
  function void parse_byte(logic [ByteW-1:0] b);
    result_t           w;
    logic [CountW-1:0] flen;
    w = '0;
    case (phase)
      PhHunt: begin
        if (b == start_marker) phase = PhLabel;
      end
      PhLabel: begin
        phase = (b == recv_label) ? PhLenLo : PhHunt;
      end
      PhLenLo: begin
        len_low = b;
        phase   = PhLenHi;
      end
      PhLenHi: begin
        flen = {b, len_low};
        if (flen < MinFrameLen) begin
          phase = PhHunt;
        end else begin
          bytes_left = flen - MinFrameLen;
          phase      = PhStatus;
        end
      end
      PhStatus: begin
        status = b[StatusW-1:0];
        phase  = PhSCode;
      end
      PhSCode: begin
        odd_code = (b != StartCodeStd);
        slot_no  = '0;
        phase    = (bytes_left == '0) ? PhEnd : PhData;
      end
      PhData: begin
        w.result_kind = KindSlot;
        w.slot_byte   = b;
        w.slot_index  = slot_no;
        expected_words.push_back(w);
        slot_no    = slot_no + 1'b1;
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) phase = PhEnd;
      end
      default: begin
        // end byte: taken whatever its value
        w.result_kind     = KindFinish;
        w.slot_index      = slot_no;
        w.queue_overflow  = status[0];
        w.receive_overrun = !status[0] && status[1];
        w.odd_start_code  = odd_code;
        w.frame_last      = 1'b1;
        expected_words.push_back(w);
        phase = PhHunt;
      end
    endcase
  endfunction

  function void mismatch(string what, longint unsigned want_v, longint unsigned got_v);
    errors++;
    if (reports < MaxReports) begin
      reports++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
    end
  endfunction

  function void check_word(result_t got);
    result_t want;
    if (expected_words.size() == 0) begin
      errors++;
      if (reports < MaxReports) begin
        reports++;
        $display("%0t: unexpected word, expected none, actual kind %0d byte %0d index %0d",
                 $time, got.result_kind, got.slot_byte, got.slot_index);
      end
      return;
    end
    want = expected_words.pop_front();
    if (got.result_kind !== want.result_kind)
      mismatch("result_kind", want.result_kind, got.result_kind);
    if (got.slot_byte !== want.slot_byte)
      mismatch("slot_byte", want.slot_byte, got.slot_byte);
    if (got.slot_index !== want.slot_index)
      mismatch("slot_index", want.slot_index, got.slot_index);
    if (got.queue_overflow !== want.queue_overflow)
      mismatch("queue_overflow", want.queue_overflow, got.queue_overflow);
    if (got.receive_overrun !== want.receive_overrun)
      mismatch("receive_overrun", want.receive_overrun, got.receive_overrun);
    if (got.odd_start_code !== want.odd_start_code)
      mismatch("odd_start_code", want.odd_start_code, got.odd_start_code);
    if (got.frame_last !== want.frame_last)
      mismatch("frame_last", want.frame_last, got.frame_last);
  endfunction

  function void drop_leftover();
    if (expected_words.size() != 0) begin
      errors++;
      $display("%0t: %0d words expected but never seen, expected index %0d, actual none",
               $time, expected_words.size(), expected_words[0].slot_index);
      expected_words.delete();
    end
  endfunction
endclass

module tb_top;
  import dmx_wfr_pkg::*;

  localparam int unsigned CycleLimit   = 3_000_000;
  localparam int          DrainCycles  = 20_000;
  localparam int          SettleCycles = 4;
  localparam int          HoldOffCycles = 300;
  localparam int          PhaseBytes   = 230;
  localparam int          GapMaxDefault = 60;
  localparam int          PhaseCount   = 6;

  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 8'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxTop   = 8'hFF;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  dmx_wfr_byte_if   rx_if ();
  dmx_wfr_cfg_if    cfg_if ();
  dmx_wfr_result_if res_if ();

  dmx_widget_frame_receiver dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  frame_scoreboard  sb;
  result_t          seen_word;
  int unsigned      cycle_count = 0;
  int               bytes_sent = 0;
  int               gap_max = GapMaxDefault;
  bit               hold_off_req = 1'b0;
  bit               hold_active = 1'b0;
  logic [ByteW-1:0] cur_marker = StartMarkerReset;
  logic [ByteW-1:0] cur_label  = RecvLabelReset;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Sample at the edge; words out are checked before the byte in is parsed.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        seen_word.result_kind     = res_if.result_kind;
        seen_word.slot_byte       = res_if.slot_byte;
        seen_word.slot_index      = res_if.slot_index;
        seen_word.queue_overflow  = res_if.queue_overflow;
        seen_word.receive_overrun = res_if.receive_overrun;
        seen_word.odd_start_code  = res_if.odd_start_code;
        seen_word.frame_last      = res_if.frame_last;
        sb.check_word(seen_word);
      end
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.cfg_index, cfg_if.cfg_data);
      if (rx_if.valid && rx_if.ready) sb.parse_byte(rx_if.rx_byte);
    end
  end

  function automatic int idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 97) n = $urandom_range(4, 12);
    else n = $urandom_range(13, 60);
    return (n > gap_max) ? gap_max : n;
  endfunction

  // Result side: random stalls, steady stretches, and the long hold-off on request.
  initial begin
    int n;
    res_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_active  = 1'b1;
        res_if.ready <= 1'b0;
        n = 0;
        while (n < HoldOffCycles) begin
          @(posedge clk_i);
          n++;
        end
        hold_active = 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(20, 200)) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
        n = idle_gap();
        if (n > 0) begin
          res_if.ready <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic sender_pause(input int n);
    if (n > 0) begin
      rx_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic put(input logic [ByteW-1:0] b, input bit steady);
    send_byte(b);
    if (!steady) sender_pause(idle_gap());
  endtask

  task automatic send_frame(input logic [CountW-1:0] flen, input logic [ByteW-1:0] status,
                            input logic [ByteW-1:0] scode, input bit steady);
    int i;
    put(cur_marker, steady);
    put(cur_label, steady);
    put(flen[7:0], steady);
    put(flen[15:8], steady);
    if (flen < MinFrameLen) return;
    put(status, steady);
    put(scode, steady);
    for (i = 0; i < int'(flen) - 2; i++) put(ByteW'($urandom), steady);
    put(ByteW'($urandom), steady);
  endtask

  // Stop offering bytes and let every expected word come out.
  task automatic drain();
    int n;
    rx_if.valid <= 1'b0;
    n = 0;
    while (sb.expected_words.size() != 0 && n < DrainCycles) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    sb.drop_leftover();
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.cfg_index <= idx;
    cfg_if.cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    if (idx == CfgIdxStartMarker) cur_marker = data;
    else if (idx == CfgIdxRecvLabel) cur_label = data;
    @(posedge clk_i);
  endtask

  function automatic logic [CountW-1:0] random_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return CountW'($urandom_range(2, 12));
    if (r < 97) return CountW'($urandom_range(13, 40));
    return CountW'(256 + $urandom_range(0, 40));
  endfunction

  function automatic logic [ByteW-1:0] random_scode();
    return ($urandom_range(0, 1) != 0) ? StartCodeStd : ByteW'($urandom);
  endfunction

  task automatic random_burst(input int phase_end);
    int               r;
    int               i;
    logic [ByteW-1:0] b;
    while (bytes_sent < phase_end) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(random_len(), ByteW'($urandom), random_scode(), $urandom_range(0, 3) == 0);
      end else if (r < 82) begin
        // line noise, mostly clear of the start marker
        for (i = 0; i < int'($urandom_range(1, 6)); i++) begin
          b = ByteW'($urandom);
          if (b == cur_marker && $urandom_range(0, 3) != 0) b = ~b;
          put(b, 1'b0);
        end
      end else if (r < 95) begin
        case ($urandom_range(0, 2))
          0: begin
            put(cur_marker, 1'b0);
            put(cur_label ^ ByteW'($urandom_range(1, 255)), 1'b0);
          end
          1: send_frame(CountW'($urandom_range(0, 1)), 8'h00, StartCodeStd, 1'b0);
          default: put(cur_marker, 1'b0);
        endcase
      end else if (r < 98) begin
        drain();
      end
    end
  endtask

  initial begin
    int               p;
    logic [ByteW-1:0] m;
    sb = new();
    rx_if.valid      <= 1'b0;
    rx_if.rx_byte    <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.cfg_index <= '0;
    cfg_if.cfg_data  <= '0;
    rst_ni           <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames under the reset register values
    send_frame(16'd2, 8'h00, StartCodeStd, 1'b1);
    send_frame(16'd3, 8'hFF, 8'hFF, 1'b0);
    put(cur_marker, 1'b0);
    put(cur_marker, 1'b0);          // bad label: must not restart the frame
    send_frame(16'd1, 8'h00, StartCodeStd, 1'b0);
    send_frame(16'd2, 8'h02, 8'h01, 1'b0);
    drain();

    for (p = 0; p < PhaseCount; p++) begin
      case (p)
        0: ;
        1: begin
          write_register(CfgIdxStartMarker, 8'h00);
          write_register(CfgIdxRecvLabel, 8'hFF);
        end
        2: begin
          write_register(CfgIdxStartMarker, 8'hFF);
          write_register(CfgIdxRecvLabel, 8'h00);
        end
        3: begin
          m = ByteW'($urandom);
          write_register(CfgIdxStartMarker, m);
          write_register(CfgIdxRecvLabel, m);
        end
        4: begin
          write_register(CfgIdxStartMarker, ByteW'($urandom));
          write_register(CfgIdxRecvLabel, ByteW'($urandom));
        end
        default: begin
          write_register(CfgIdxStartMarker, StartMarkerReset);
          write_register(CfgIdxRecvLabel, RecvLabelReset);
        end
      endcase
      // writes to unmapped indexes must leave the registers alone
      write_register((p % 2 != 0) ? CfgIdxSpare : CfgIdxTop, ByteW'($urandom));

      if (p == 1 || p == 4) begin
        rx_if.valid <= 1'b0;
        hold_off_req = 1'b1;
        while (!hold_active) @(posedge clk_i);
        send_frame(16'd40, ByteW'($urandom), random_scode(), 1'b1);
      end
      random_burst(bytes_sent + PhaseBytes);
      drain();
    end

    // one long frame, past a length high byte of one, with short gaps only
    gap_max = 2;
    send_frame(16'd258, 8'h01, StartCodeStd, 1'b0);
    gap_max = GapMaxDefault;
    drain();

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

@@ dmx_widget_frame_receiver.f @@
+incdir+hw/rtl
hw/rtl/dmx_wfr_pkg.sv
hw/rtl/dmx_wfr_byte_if.sv
hw/rtl/dmx_wfr_result_if.sv
hw/rtl/dmx_wfr_cfg_if.sv
hw/rtl/dmx_wfr_parser.sv
hw/rtl/dmx_widget_frame_receiver.sv
tb/tb_top.sv
